FILE: hw/rtl/magnetometer_calibrate_heading_assert.svh
// Assertion macros used by the magnetometer heading checker.
`ifndef MAGNETOMETER_CALIBRATE_HEADING_ASSERT_SVH
`define MAGNETOMETER_CALIBRATE_HEADING_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MCH_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MCH_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/mch_pkg.sv
// Shared widths, constants and the arctangent table of the magnetometer heading block.
`default_nettype none

package mch_pkg;

  // Stream and configuration widths.
  localparam int unsigned RAW_W      = 16;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned OUT_USER_W = 1;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Field and state widths.
  localparam int unsigned SCL_W  = 15;
  localparam int unsigned FXY_W  = 15;
  localparam int unsigned FZ_W   = 16;
  localparam int unsigned HDG_W  = 17;
  localparam int unsigned HSUM_W = 18;
  localparam int unsigned CAL_W  = 16;
  localparam int unsigned DECL_W = 15;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_SAMPLES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECLINATION = 1'b1;

  // Configuration reset values (declination is -141 in 1/64 degree).
  localparam logic [CAL_W-1:0]  CAL_SAMPLES_RST = 16'd1000;
  localparam logic [DECL_W-1:0] DECL_RST        = 15'h7F73;

  // CORDIC datapath.
  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned ATAN_LEN         = 24;
  localparam int unsigned ATAN_IDX_W       = 5;
  localparam int unsigned CX_W             = 33;
  localparam int unsigned ANG_W            = 24;
  localparam int unsigned PRESCALE         = 16;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q20 = 24'sd1647099;

  // Shared multiplier and the constants it is used with.
  localparam int unsigned MUL_A_W       = 22;
  localparam int unsigned MUL_B_W       = 17;
  localparam int unsigned MUL_P_W       = 39;
  localparam int unsigned RECIP5_SHIFT  = 17;
  localparam int unsigned DEG_SHIFT     = 20;
  localparam int unsigned RECIP10_SHIFT = 20;
  localparam int unsigned NQ_W          = 18;
  localparam int unsigned QUOT_W        = 15;
  localparam logic [MUL_B_W-1:0] RECIP5    = 17'd26215;
  localparam logic [MUL_B_W-1:0] DEG64_NUM = 17'd36672;
  localparam logic [MUL_B_W-1:0] RECIP10   = 17'd104858;
  localparam logic [MUL_P_W-1:0] DEG_ROUND = 39'd5242880;
  localparam logic signed [HSUM_W-1:0] BASE_HEADING = 18'sd11520;

  // Arctangent of 2^-i in Q20 radians, rounded to nearest.
  function automatic logic [ANG_W-2:0] atan_q20(input logic [ATAN_IDX_W-1:0] idx);
    logic [ANG_W-2:0] val;
    unique case (idx)
      5'd0:    val = 23'd823550;
      5'd1:    val = 23'd486170;
      5'd2:    val = 23'd256879;
      5'd3:    val = 23'd130396;
      5'd4:    val = 23'd65451;
      5'd5:    val = 23'd32757;
      5'd6:    val = 23'd16383;
      5'd7:    val = 23'd8192;
      5'd8:    val = 23'd4096;
      5'd9:    val = 23'd2048;
      5'd10:   val = 23'd1024;
      5'd11:   val = 23'd512;
      5'd12:   val = 23'd256;
      5'd13:   val = 23'd128;
      5'd14:   val = 23'd64;
      5'd15:   val = 23'd32;
      5'd16:   val = 23'd16;
      5'd17:   val = 23'd8;
      5'd18:   val = 23'd4;
      5'd19:   val = 23'd2;
      5'd20:   val = 23'd1;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/magnetometer_calibrate_heading.sv
// Magnetometer hard-iron calibration and compass heading, top level.
//
// Each accepted sample gives exactly one result. After reset the block
// calibrates: the first sample and the next cal_samples samples set the
// per-axis minimum and maximum, and the results of those samples are all
// zero with heading_valid low. Later samples are offset-corrected and get a
// heading in 1/64 degree from a vectoring CORDIC. The block works on one
// sample at a time and is not ready while it does: a calibration sample
// goes through the scaling and calibration steps (and the offset step on the
// sample that ends calibration), a heading sample through scaling, the
// CORDIC rotations and the degree conversion. The CORDIC runs one rotation
// per cycle on one set of adders, and the scaling and the degree conversion
// share a single multiplier. When the corrected x and y are both zero the
// rotations are skipped. A finished result sits in an output register, so
// the next sample can enter while it waits; that next sample then holds in
// its last step for as long as the output register stays full.
`default_nettype none

module magnetometer_calibrate_heading #(
  parameter int unsigned CORDIC_STEPS = mch_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [mch_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mch_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // Sample stream.
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [mch_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,  // raw_x, raw_y, raw_z
  // Result stream.
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [mch_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,  // field_x, field_y, field_z,
                                                             // heading, zero pad
  output logic [mch_pkg::OUT_USER_W-1:0]    m_axis_tuser_o   // heading_valid
);

  import mch_pkg::*;

  localparam int unsigned NUM_ITER = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int unsigned ITER_W   = (NUM_ITER > 1) ? $clog2(NUM_ITER) : 1;

  // Sequencer states.
  localparam int unsigned ST_W    = 4;
  localparam logic [ST_W-1:0] ST_IDLE = 4'd0;
  localparam logic [ST_W-1:0] ST_SCX  = 4'd1;
  localparam logic [ST_W-1:0] ST_SCY  = 4'd2;
  localparam logic [ST_W-1:0] ST_CAL  = 4'd3;
  localparam logic [ST_W-1:0] ST_OFS  = 4'd4;
  localparam logic [ST_W-1:0] ST_LOAD = 4'd5;
  localparam logic [ST_W-1:0] ST_ROT  = 4'd6;
  localparam logic [ST_W-1:0] ST_DEG1 = 4'd7;
  localparam logic [ST_W-1:0] ST_DEG2 = 4'd8;
  localparam logic [ST_W-1:0] ST_OUT  = 4'd9;

  logic [ST_W-1:0] state_q, state_d;

  // Configuration.
  logic [CAL_W-1:0]  cal_samples_q, cal_samples_d;
  logic [DECL_W-1:0] decl_q, decl_d;

  // Calibration state.
  logic              calibrating_q, calibrating_d;
  logic              have_first_q, have_first_d;
  logic [CAL_W-1:0]  count_q, count_d;
  logic signed [SCL_W-1:0] min_q [3];
  logic signed [SCL_W-1:0] min_d [3];
  logic signed [SCL_W-1:0] max_q [3];
  logic signed [SCL_W-1:0] max_d [3];
  logic signed [SCL_W-1:0] off_q [3];
  logic signed [SCL_W-1:0] off_d [3];

  // Sample and working registers.
  logic signed [RAW_W-1:0] raw_x_q, raw_x_d, raw_y_q, raw_y_d, raw_z_q, raw_z_d;
  logic signed [SCL_W-1:0] sx_q, sx_d, sy_q, sy_d, sz_q, sz_d;
  logic signed [FXY_W-1:0] fx_q, fx_d, fy_q, fy_d;
  logic signed [FZ_W-1:0]  fz_q, fz_d;
  logic [HDG_W-1:0]        hd_q, hd_d;
  logic                    hv_q, hv_d;
  logic signed [CX_W-1:0]  cx_q, cx_d, cy_q, cy_d;
  logic signed [ANG_W-1:0] ang_q, ang_d;
  logic [ITER_W-1:0]       iter_q, iter_d;
  logic [NQ_W-1:0]         nq_q, nq_d;

  // Output register.
  logic                    out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0]   out_data_q, out_data_d;
  logic [OUT_USER_W-1:0]   out_user_q, out_user_d;

  // Shared multiplier.
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  // Scaling datapath.
  logic signed [RAW_W-1:0] sc_raw;
  logic [RAW_W-1:0]        sc_mag;
  logic [RAW_W:0]          sc_mag3;
  logic [SCL_W-1:0]        sc_q;
  logic signed [SCL_W-1:0] sc_val;
  logic [RAW_W-1:0]        z_mag;
  logic signed [SCL_W-1:0] z_val;

  // Calibration helpers.
  logic signed [SCL_W-1:0] cal_s [3];
  logic [CAL_W-1:0]        count_inc;
  logic signed [SCL_W:0]   span [3];

  // Correction and CORDIC helpers.
  logic signed [FXY_W-1:0] fx_c, fy_c;
  logic signed [FZ_W-1:0]  fz_c;
  logic signed [CX_W-1:0]  px, py, sh_x, sh_y;
  logic [ANG_W-2:0]        atan_val;
  logic [ANG_W-1:0]        ang_mag;
  logic [MUL_P_W-1:0]      deg_sum;
  logic [QUOT_W-1:0]       quot;
  logic signed [HSUM_W-1:0] deg_s, hsum;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  // Multiplier operand selection: scaling, then the two degree conversion steps.
  always_comb begin
    mul_a = MUL_A_W'(sc_mag3[RAW_W:2]);
    mul_b = RECIP5;
    unique case (state_q)
      ST_DEG1: begin
        mul_a = ang_mag[MUL_A_W-1:0];
        mul_b = DEG64_NUM;
      end
      ST_DEG2: begin
        mul_a = MUL_A_W'(nq_q);
        mul_b = RECIP10;
      end
      default: ;
    endcase
  end

  assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

  // Scaling by 15/100 is floor(3|r| / 20) with the sign put back; z by 25/100 is r/4.
  assign sc_raw  = (state_q == ST_SCY) ? raw_y_q : raw_x_q;
  assign sc_mag  = sc_raw[RAW_W-1] ? RAW_W'(-sc_raw) : RAW_W'(sc_raw);
  assign sc_mag3 = {1'b0, sc_mag} + {sc_mag, 1'b0};
  assign sc_q    = mul_p[RECIP5_SHIFT +: SCL_W];
  assign sc_val  = sc_raw[RAW_W-1] ? -$signed(sc_q) : $signed(sc_q);
  assign z_mag   = raw_z_q[RAW_W-1] ? RAW_W'(-raw_z_q) : RAW_W'(raw_z_q);
  assign z_val   = raw_z_q[RAW_W-1] ? -$signed({1'b0, z_mag[RAW_W-1:2]})
                                    : $signed({1'b0, z_mag[RAW_W-1:2]});

  // Calibration helpers.
  assign cal_s[0]  = sx_q;
  assign cal_s[1]  = sy_q;
  assign cal_s[2]  = sz_q;
  assign count_inc = (count_q != '1) ? count_q + 1'b1 : count_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      span[k] = $signed({max_q[k][SCL_W-1], max_q[k]}) - $signed({min_q[k][SCL_W-1], min_q[k]});
    end
  end

  // Offset correction with x negated, and the CORDIC pre-rotation inputs.
  assign fx_c = off_q[0] - sx_q;
  assign fy_c = sy_q - off_q[1];
  assign fz_c = $signed({sz_q[SCL_W-1], sz_q}) - $signed({off_q[2][SCL_W-1], off_q[2]});
  assign px   = $signed({{(CX_W-FXY_W-PRESCALE){fx_c[FXY_W-1]}}, fx_c, {PRESCALE{1'b0}}});
  assign py   = $signed({{(CX_W-FXY_W-PRESCALE){fy_c[FXY_W-1]}}, fy_c, {PRESCALE{1'b0}}});

  // One CORDIC rotation, shifts rounding toward minus infinity.
  assign sh_x     = cx_q >>> iter_q;
  assign sh_y     = cy_q >>> iter_q;
  assign atan_val = atan_q20(ATAN_IDX_W'(iter_q));

  // Degree conversion: round(|A| * 36672 / (10 * 2^20)), half away from zero.
  assign ang_mag = ang_q[ANG_W-1] ? ANG_W'(-ang_q) : ANG_W'(ang_q);
  assign deg_sum = mul_p + DEG_ROUND;
  assign quot    = mul_p[RECIP10_SHIFT +: QUOT_W];
  assign deg_s   = ang_q[ANG_W-1] ? -$signed({{(HSUM_W-QUOT_W){1'b0}}, quot})
                                  : $signed({{(HSUM_W-QUOT_W){1'b0}}, quot});
  assign hsum    = BASE_HEADING + deg_s
                 + $signed({{(HSUM_W-DECL_W){decl_q[DECL_W-1]}}, decl_q});

  // Sequencer and datapath next state.
  always_comb begin
    state_d       = state_q;
    cal_samples_d = cal_samples_q;
    decl_d        = decl_q;
    calibrating_d = calibrating_q;
    have_first_d  = have_first_q;
    count_d       = count_q;
    min_d         = min_q;
    max_d         = max_q;
    off_d         = off_q;
    raw_x_d       = raw_x_q;
    raw_y_d       = raw_y_q;
    raw_z_d       = raw_z_q;
    sx_d          = sx_q;
    sy_d          = sy_q;
    sz_d          = sz_q;
    fx_d          = fx_q;
    fy_d          = fy_q;
    fz_d          = fz_q;
    hd_d          = hd_q;
    hv_d          = hv_q;
    cx_d          = cx_q;
    cy_d          = cy_q;
    ang_d         = ang_q;
    iter_d        = iter_q;
    nq_d          = nq_q;
    out_valid_d   = out_valid_q;
    out_data_d    = out_data_q;
    out_user_d    = out_user_q;

    // Configuration writes.
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CAL_SAMPLES: cal_samples_d = cfg_data_i[CAL_W-1:0];
        CFG_DECLINATION: decl_d        = cfg_data_i[DECL_W-1:0];
      endcase
    end

    // The result register empties on a transfer.
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          raw_x_d = $signed(s_axis_tdata_i[0 +: RAW_W]);
          raw_y_d = $signed(s_axis_tdata_i[RAW_W +: RAW_W]);
          raw_z_d = $signed(s_axis_tdata_i[2*RAW_W +: RAW_W]);
          state_d = ST_SCX;
        end
      end

      ST_SCX: begin
        sx_d    = sc_val;
        sz_d    = z_val;
        state_d = ST_SCY;
      end

      ST_SCY: begin
        sy_d    = sc_val;
        state_d = calibrating_q ? ST_CAL : ST_LOAD;
      end

      // Widen the per-axis range and decide whether calibration ends here.
      ST_CAL: begin
        fx_d = '0;
        fy_d = '0;
        fz_d = '0;
        hd_d = '0;
        hv_d = 1'b0;
        state_d = ST_OUT;
        if (!have_first_q) begin
          for (int k = 0; k < 3; k++) begin
            min_d[k] = cal_s[k];
            max_d[k] = cal_s[k];
          end
          have_first_d = 1'b1;
          if (cal_samples_q == '0) begin
            state_d = ST_OFS;
          end
        end else begin
          for (int k = 0; k < 3; k++) begin
            if (min_q[k] > cal_s[k]) begin
              min_d[k] = cal_s[k];
            end else if (max_q[k] < cal_s[k]) begin
              max_d[k] = cal_s[k];
            end
          end
          count_d = count_inc;
          if (count_inc >= cal_samples_q) begin
            state_d = ST_OFS;
          end
        end
      end

      // Offsets sit halfway between the minimum and the maximum.
      ST_OFS: begin
        for (int k = 0; k < 3; k++) begin
          off_d[k] = min_q[k] + $signed(span[k][SCL_W:1]);
        end
        calibrating_d = 1'b0;
        state_d       = ST_OUT;
      end

      // Correct the sample and start the CORDIC, turning left-half vectors by pi/2.
      ST_LOAD: begin
        fx_d   = fx_c;
        fy_d   = fy_c;
        fz_d   = fz_c;
        iter_d = '0;
        if (fx_c < 0) begin
          if (fy_c >= 0) begin
            cx_d  = py;
            cy_d  = -px;
            ang_d = HALF_PI_Q20;
          end else begin
            cx_d  = -py;
            cy_d  = px;
            ang_d = -HALF_PI_Q20;
          end
        end else begin
          cx_d  = px;
          cy_d  = py;
          ang_d = '0;
        end
        if (fx_c == '0 && fy_c == '0) begin
          ang_d   = '0;
          state_d = ST_DEG1;
        end else begin
          state_d = ST_ROT;
        end
      end

      // One rotation toward the x axis per cycle.
      ST_ROT: begin
        if (cy_q >= 0) begin
          cx_d  = cx_q + sh_y;
          cy_d  = cy_q - sh_x;
          ang_d = ang_q + $signed({1'b0, atan_val});
        end else begin
          cx_d  = cx_q - sh_y;
          cy_d  = cy_q + sh_x;
          ang_d = ang_q - $signed({1'b0, atan_val});
        end
        iter_d = iter_q + 1'b1;
        if (iter_q == ITER_W'(NUM_ITER - 1)) begin
          state_d = ST_DEG1;
        end
      end

      ST_DEG1: begin
        nq_d    = deg_sum[DEG_SHIFT +: NQ_W];
        state_d = ST_DEG2;
      end

      ST_DEG2: begin
        hd_d    = hsum[HDG_W-1:0];
        hv_d    = 1'b1;
        state_d = ST_OUT;
      end

      // Hand the result to the output register once it is free.
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = {1'b0, hd_q, fz_q, fy_q, fx_q};
          out_user_d  = hv_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cal_samples_q <= CAL_SAMPLES_RST;
      decl_q        <= DECL_RST;
      calibrating_q <= 1'b1;
      have_first_q  <= 1'b0;
      count_q       <= '0;
      iter_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      cal_samples_q <= cal_samples_d;
      decl_q        <= decl_d;
      calibrating_q <= calibrating_d;
      have_first_q  <= have_first_d;
      count_q       <= count_d;
      iter_q        <= iter_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    min_q      <= min_d;
    max_q      <= max_d;
    off_q      <= off_d;
    raw_x_q    <= raw_x_d;
    raw_y_q    <= raw_y_d;
    raw_z_q    <= raw_z_d;
    sx_q       <= sx_d;
    sy_q       <= sy_d;
    sz_q       <= sz_d;
    fx_q       <= fx_d;
    fy_q       <= fy_d;
    fz_q       <= fz_d;
    hd_q       <= hd_d;
    hv_q       <= hv_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    ang_q      <= ang_d;
    nq_q       <= nq_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mch_checker.sv
// Port-level checker for the magnetometer heading block, bound to its top level.
`default_nettype none

`include "magnetometer_calibrate_heading_assert.svh"

module mch_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid_i,
  input logic                              s_axis_tready_o,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [mch_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,  // field_x, field_y, field_z,
                                                            // heading, zero pad
  input logic [mch_pkg::OUT_USER_W-1:0]    m_axis_tuser_o   // heading_valid
);

  import mch_pkg::*;

  // The block works on one sample at a time, so it is busy right after a transfer in.
  `MCH_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "block ready right after taking a sample")

  // Results produced during calibration carry all-zero fields.
  `MCH_ASSERT_SAME(a_cal_result_zero, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tuser_o[0], m_axis_tdata_o == '0, "calibration result is not zero")

  // The corrected x field stays within twice the scaled sensor range.
  `MCH_ASSERT_SAME(a_field_x_range, clk_i, rst_ni, m_axis_tvalid_o, ($signed(m_axis_tdata_o[14:0]) >= -15'sd9830) && ($signed(m_axis_tdata_o[14:0]) <= 15'sd9830), "field_x out of range")

  // A stalled result holds its contents.
  `MCH_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "stalled result changed")

endmodule

bind magnetometer_calibrate_heading mch_checker u_mch_checker (.*);

`default_nettype wire
